@@ rtl/rts_pkg.sv @@
// Package: table size, record type, cell operations and controller states.
`timescale 1ns / 1ps
package rts_pkg;

  localparam int ENTRIES = 8;
  localparam int CNT_W   = $clog2(ENTRIES);

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int NUM_W   = 16;
  localparam int HOUR_W  = 16;
  localparam int PAY_W   = 64;
  localparam int POS_W   = 3;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SORT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [HOUR_W-1:0] hour;
    logic [PAY_W-1:0]  pay;
  } rec_t;

  // Per-cell operation, selected by the controller.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ROT,   // take right neighbor (ring)
    OP_LOW,   // lower cell of a compare-exchange pair
    OP_UP     // upper cell of a compare-exchange pair
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT,
    ST_MISS
  } st_t;

endpackage

@@ rtl/rts_in_if.sv @@
// Interfaces for the command channel and the result channel.
`timescale 1ns / 1ps
interface rts_in_if;
  import rts_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [NUM_W-1:0]  turn_number;
  logic [HOUR_W-1:0] hour;
  logic [PAY_W-1:0]  payload;
  modport source(output valid, kind, slot, turn_number, hour, payload, input ready);
  modport sink(input valid, kind, slot, turn_number, hour, payload, output ready);
endinterface

interface rts_out_if;
  import rts_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [POS_W-1:0]  position;
  logic [NUM_W-1:0]  turn_number_out;
  logic [HOUR_W-1:0] hour_out;
  logic [PAY_W-1:0]  payload_out;
  logic              last;
  modport source(output valid, found, position, turn_number_out, hour_out, payload_out,
                 last, input ready);
  modport sink(input valid, found, position, turn_number_out, hour_out, payload_out,
               last, output ready);
endinterface

@@ rtl/record_table_sort_search_core.sv @@
// Top level: record table as a ring of cells with sort, search and list control.
// Load: writes one cell, no result. List and search hit: the ring rotates through every
//   position and records are registered in position order; search miss: one not-found word.
// Sort: ENTRIES odd-even transposition phases on hour, then every record is emitted as in list.
// Next word taken the cycle after the run ends; a blocked result word stalls rotation.
// Reset (rst_n low, synchronous) zeroes every record and idles the controller.
`timescale 1ns / 1ps
module record_table_sort_search_core (
  input logic clk,
  input logic rst_n,
  rts_in_if.sink    in_ch,
  rts_out_if.source out_ch
);
  import rts_pkg::*;

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // sort phase or rotation count
  logic             srch_r, srch_nxt;    // emit only matching records
  logic [ENTRIES-1:0] mask_r, mask_nxt;  // search hits, by table position

  rec_t     rec   [ENTRIES];
  cell_op_t op    [ENTRIES];
  rec_t     ld_rec;

  // output register
  logic              out_valid_r;
  logic              found_r, last_r;
  logic [POS_W-1:0]  pos_r;
  rec_t              orec_r;

  logic in_fire, out_free;
  logic emit_now;     // cell 0 holds a record that goes out this step
  logic step;         // ring rotates this cycle
  logic sort_en;
  logic miss_go;
  logic cnt_end;
  logic emit_last;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] above;
  logic [31:0]        cnt32;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_end  = (cnt_r == CNT_W'(ENTRIES - 1));
  assign cnt32    = 32'(cnt_r);

  assign ld_rec = '{num: in_ch.turn_number, hour: in_ch.hour, pay: in_ch.payload};

  // per-cell match against the searched number
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = (rec[i].num == in_ch.turn_number);
    end
  end

  // in a search, hits beyond the current position decide the last flag; else the final position does
  assign above     = (mask_r >> cnt_r) >> 1;
  assign emit_last = srch_r ? (above == '0) : cnt_end;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    srch_nxt  = srch_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          priority case (in_ch.kind)
            KIND_SEARCH: begin
              srch_nxt  = 1'b1;
              mask_nxt  = hit;
              state_nxt = (hit == '0) ? ST_MISS : ST_EMIT;
            end
            KIND_SORT: begin
              srch_nxt  = 1'b0;
              state_nxt = ST_SORT;
            end
            KIND_LIST: begin
              srch_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;   // load: done in the accept cycle
          endcase
        end
      end
      ST_SORT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MISS: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the controller
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    emit_now    = 1'b0;
    step        = 1'b0;
    sort_en     = 1'b0;
    miss_go     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SORT: sort_en = 1'b1;
      ST_EMIT: begin
        emit_now = srch_r ? mask_r[cnt_r] : 1'b1;
        step     = !emit_now || out_free;   // stall only on a blocked word
      end
      ST_MISS: miss_go = out_free;
      default: in_ch.ready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Cell ring
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam int RI = (i + 1) % ENTRIES;
    localparam int LI = (i + ENTRIES - 1) % ENTRIES;

    always_comb begin
      op[i] = OP_HOLD;
      if (in_fire && (in_ch.kind == KIND_LOAD) && (32'(in_ch.slot) == i)) begin
        op[i] = OP_LOAD;   // out-of-range slots match no cell
      end else if ((state_r == ST_EMIT) && step) begin
        op[i] = OP_ROT;
      end else if (sort_en) begin
        // phase parity picks even or odd pairs
        if (((i % 2) == int'(cnt_r[0])) && (i < ENTRIES - 1)) begin
          op[i] = OP_LOW;
        end else if (((i % 2) != int'(cnt_r[0])) && (i > 0)) begin
          op[i] = OP_UP;
        end
      end
    end

    rts_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op[i]),
      .ld    (ld_rec),
      .lft   (rec[LI]),
      .rgt   (rec[RI]),
      .q     (rec[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      srch_r      <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      srch_r   <= srch_nxt;
      mask_r   <= mask_nxt;
      if ((emit_now && out_free) || miss_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word: cell 0 holds the record at position cnt_r; a search miss gives a not-found word
  always_ff @(posedge clk) begin
    if (emit_now && out_free) begin
      found_r <= 1'b1;
      last_r  <= emit_last;
      pos_r   <= cnt32[POS_W-1:0];
      orec_r  <= rec[0];
    end else if (miss_go) begin
      found_r <= 1'b0;
      last_r  <= 1'b1;
      pos_r   <= '0;
      orec_r  <= '0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = found_r;
  assign out_ch.last            = last_r;
  assign out_ch.position        = pos_r;
  assign out_ch.turn_number_out = orec_r.num;
  assign out_ch.hour_out        = orec_r.hour;
  assign out_ch.payload_out     = orec_r.pay;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("word accepted while ring busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES - 1))
    else $error("phase/rotation count out of range");

  a_list_every_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !srch_r) |-> emit_now)
    else $error("list/sort run skipped a record");

  a_sort_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SORT) && cnt_end) |=> (state_r == ST_EMIT))
    else $error("sort did not hand over to emit");

endmodule

@@ rtl/rts_cell.sv @@
// One table cell: holds a record, loads, rotates or compare-exchanges with a neighbor.
`timescale 1ns / 1ps
module rts_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rts_pkg::cell_op_t op,
  input  rts_pkg::rec_t     ld,
  input  rts_pkg::rec_t     lft,
  input  rts_pkg::rec_t     rgt,
  output rts_pkg::rec_t     q
);
  import rts_pkg::*;

  rec_t rec_r, rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    unique case (op)
      OP_HOLD: rec_nxt = rec_r;
      OP_LOAD: rec_nxt = ld;
      OP_ROT:  rec_nxt = rgt;
      // strict compare keeps equal hours in place
      OP_LOW:  if (rec_r.hour > rgt.hour) rec_nxt = rgt;
      OP_UP:   if (lft.hour > rec_r.hour) rec_nxt = lft;
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign q = rec_r;

endmodule
